// ----- sv/tg3_pkg.sv -----
// ----------------------------------------------------------------------------
// tg3_pkg
// Shared types and constants for the toroidal 3x3 grid blur unit.
// ----------------------------------------------------------------------------
package tg3_pkg;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int VAL_W   = 16;
    localparam int SIZE_W  = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int ADDR_W  = ROW_W + COL_W;

    localparam logic [SIZE_W-1:0] MAX_ROWS = 7'd64;
    localparam logic [SIZE_W-1:0] MAX_COLS = 7'd64;

    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [VAL_W-1:0]  BLUR_AMOUNT_RST = 16'd7864;

    // register indexes on the config port
    localparam logic [CFG_A_W-1:0] CFG_GRID_HEIGHT = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_BLUR_AMOUNT = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // neighbour sequence: centre, four sides, four corners
    localparam logic [3:0] NBR_LAST = 4'd8;

    // (x * RECIP3) >> RECIP3_SH equals x / 3 for x below 2^19
    localparam logic [17:0] RECIP3    = 18'd174763;
    localparam int          RECIP3_SH = 19;
    localparam logic [36:0] HALF_DEN  = 37'd393216;

    typedef struct packed {
        logic              op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  cell_value;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [VAL_W-1:0]  blurred_value;
        logic              out_of_range;
    } out_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_READ_OOR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  up;
        logic [ROW_W-1:0]  dn;
        logic [COL_W-1:0]  lf;
        logic [COL_W-1:0]  rt;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_DRAIN,
        BK_MUL,
        BK_SUM,
        BK_DIV
    } bk_state_t;

endpackage

// ----- sv/tg3_front.sv -----
// ----------------------------------------------------------------------------
// tg3_front
// Accepts requests, classifies them against the grid size and works out
// the wrapped neighbour rows and columns for the back end.
// ----------------------------------------------------------------------------
module tg3_front
    import tg3_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    input  logic [SIZE_W-1:0] grid_height,
    input  logic [SIZE_W-1:0] grid_width,
    input  fifo_stat_t        fifo_stat,
    input  back_stat_t        back_stat,
    output logic              push,
    output cmd_t              cmd
);

    logic [SIZE_W-1:0] h_eff;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_m1;
    logic [SIZE_W-1:0] w_m1;
    logic              on_grid;

    always_comb begin
        if (grid_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (grid_height > MAX_ROWS) begin
            h_eff = MAX_ROWS;
        end else begin
            h_eff = grid_height;
        end
        if (grid_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (grid_width > MAX_COLS) begin
            w_eff = MAX_COLS;
        end else begin
            w_eff = grid_width;
        end
        h_m1 = h_eff - SIZE_W'(1);
        w_m1 = w_eff - SIZE_W'(1);
        on_grid = ({1'b0, s_data.row} < h_eff) && ({1'b0, s_data.col} < w_eff);

        cmd.row   = s_data.row;
        cmd.col   = s_data.col;
        cmd.value = s_data.cell_value;
        cmd.up    = (s_data.row == '0) ? h_m1[ROW_W-1:0] : s_data.row - ROW_W'(1);
        cmd.dn    = ({1'b0, s_data.row} == h_m1) ? '0 : s_data.row + ROW_W'(1);
        cmd.lf    = (s_data.col == '0) ? w_m1[COL_W-1:0] : s_data.col - COL_W'(1);
        cmd.rt    = ({1'b0, s_data.col} == w_m1) ? '0 : s_data.col + COL_W'(1);

        if (s_data.op == OP_WRITE) begin
            cmd.kind = CMD_WRITE;
        end else if (on_grid) begin
            cmd.kind = CMD_READ;
        end else begin
            cmd.kind = CMD_READ_OOR;
        end

        s_ready = !fifo_stat.full && !back_stat.clearing;
        // writes outside the grid are dropped here
        push = s_valid && s_ready && !(s_data.op == OP_WRITE && !on_grid);
    end

endmodule

// ----- sv/tg3_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tg3_cmd_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module tg3_cmd_fifo
    import tg3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  cmd_t       push_cmd,
    input  logic       pop,
    output cmd_t       head_cmd,
    output fifo_stat_t stat
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_next;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        stat.full   = (count_reg == 2'd2);
        stat.empty  = (count_reg == 2'd0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
        head_cmd    = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/tg3_back.sv -----
// ----------------------------------------------------------------------------
// tg3_back
// Owns the cell store. Executes writes, gathers the nine neighbours of a
// read one store access per cycle, weights, rounds and divides the sum.
// ----------------------------------------------------------------------------
module tg3_back
    import tg3_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [VAL_W-1:0] blur_amount,
    input  fifo_stat_t       fifo_stat,
    input  cmd_t             head_cmd,
    output logic             pop,
    output back_stat_t       stat,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    logic [VAL_W-1:0] mem [1 << ADDR_W];

    bk_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    cmd_t             cur_reg, cur_next;
    logic [3:0]       k_reg, k_next;
    logic [3:0]       tag_reg;
    logic             pend_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic [15:0]      c_reg, c_next;
    logic [17:0]      s_reg, s_next;
    logic [17:0]      g_reg, g_next;
    logic [32:0]      p1_reg, p1_next;
    logic [35:0]      p2_reg, p2_next;
    logic [19:0]      q1_reg, q1_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg, out_data_next;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  sel_row;
    logic [COL_W-1:0]  sel_col;
    logic              out_free;
    logic [36:0]       num;
    logic [35:0]       div_prod;
    logic [16:0]       quot;
    logic [19:0]       wsum;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        g_next         = g_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        q1_next        = q1_reg;
        out_free       = !out_valid_reg || m_ready;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = head_cmd.value;
        mem_addr       = {head_cmd.row, head_cmd.col};
        num            = '0;
        div_prod       = '0;
        quot           = '0;
        wsum           = 20'({s_reg, 1'b0}) + 20'(g_reg);

        // neighbour selection for the current gather step
        case (k_reg)
            4'd0:    begin sel_row = cur_reg.row; sel_col = cur_reg.col; end
            4'd1:    begin sel_row = cur_reg.up;  sel_col = cur_reg.col; end
            4'd2:    begin sel_row = cur_reg.dn;  sel_col = cur_reg.col; end
            4'd3:    begin sel_row = cur_reg.row; sel_col = cur_reg.lf;  end
            4'd4:    begin sel_row = cur_reg.row; sel_col = cur_reg.rt;  end
            4'd5:    begin sel_row = cur_reg.up;  sel_col = cur_reg.lf;  end
            4'd6:    begin sel_row = cur_reg.up;  sel_col = cur_reg.rt;  end
            4'd7:    begin sel_row = cur_reg.dn;  sel_col = cur_reg.lf;  end
            default: begin sel_row = cur_reg.dn;  sel_col = cur_reg.rt;  end
        endcase

        // registered read data lands in the cycle after its address
        if (pend_reg) begin
            if (tag_reg == 4'd0) begin
                c_next = rd_data_reg;
            end else if (tag_reg < 4'd5) begin
                s_next = s_reg + 18'(rd_data_reg);
            end else begin
                g_next = g_reg + 18'(rd_data_reg);
            end
        end

        case (state_reg)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!fifo_stat.empty) begin
                    case (head_cmd.kind)
                        CMD_WRITE: begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        CMD_READ: begin
                            pop        = 1'b1;
                            cur_next   = head_cmd;
                            k_next     = '0;
                            c_next     = '0;
                            s_next     = '0;
                            g_next     = '0;
                            state_next = BK_READ;
                        end
                        CMD_READ_OOR: begin
                            if (out_free) begin
                                pop                         = 1'b1;
                                out_valid_next              = 1'b1;
                                out_data_next.out_row       = head_cmd.row;
                                out_data_next.out_col       = head_cmd.col;
                                out_data_next.blurred_value = '0;
                                out_data_next.out_of_range  = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                mem_re   = 1'b1;
                mem_addr = {sel_row, sel_col};
                k_next   = k_reg + 4'd1;
                if (k_reg == NBR_LAST) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                state_next = BK_MUL;
            end
            BK_MUL: begin
                p1_next    = 33'(17'h10000 - {1'b0, blur_amount}) * 33'(c_reg);
                p2_next    = 36'(blur_amount) * 36'(wsum);
                state_next = BK_SUM;
            end
            BK_SUM: begin
                // 12 * p1 + p2, plus half the denominator for rounding
                num        = 37'({p1_reg, 3'b000}) + 37'({p1_reg, 2'b00})
                           + 37'(p2_reg) + HALF_DEN;
                q1_next    = num[35:16];
                state_next = BK_DIV;
            end
            BK_DIV: begin
                div_prod = 36'(q1_reg[19:2]) * 36'(RECIP3);
                quot     = div_prod[RECIP3_SH +: 17];
                if (out_free) begin
                    out_valid_next              = 1'b1;
                    out_data_next.out_row       = cur_reg.row;
                    out_data_next.out_col       = cur_reg.col;
                    out_data_next.blurred_value = quot[16] ? '1 : quot[15:0];
                    out_data_next.out_of_range  = 1'b0;
                    state_next                  = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        stat.clearing = (state_reg == BK_CLEAR);
        m_valid       = out_valid_reg;
        m_data        = out_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            pend_reg      <= mem_re;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        tag_reg      <= k_reg;
        c_reg        <= c_next;
        s_reg        <= s_next;
        g_reg        <= g_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        q1_reg       <= q1_next;
        out_data_reg <= out_data_next;
    end

    // single-port cell store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

endmodule

// ----- sv/toroidal_grid_blur_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// toroidal_grid_blur_3x3_unit
// Grid of Q0.16 cells with a wrapped 3x3 blur read-out.
//
//   channel   ports                      direction  carries
//   s_        s_valid s_ready s_data     in         in_t   write or read request
//   m_        m_valid m_ready m_data     out        out_t  blurred cell per read
//   cfg_      cfg_we cfg_addr cfg_wdata  in         grid size and blur amount
//
// In the back end a write is done in the idle state; an in-grid read
// gathers the nine neighbours from the single-port cell store, one per
// cycle, then drains, multiplies, sums and divides. Reads outside the grid
// are answered from the idle state. After reset a clearing pass zeroes the
// store; s_ready stays low meanwhile. A two-entry queue keeps accepting while
// the back end works, and the output register holds a result until m_ready.
// ----------------------------------------------------------------------------
module toroidal_grid_blur_3x3_unit
    import tg3_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    logic [SIZE_W-1:0] grid_height_reg;
    logic [SIZE_W-1:0] grid_width_reg;
    logic [VAL_W-1:0]  blur_amount_reg;

    logic       push;
    logic       pop;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    fifo_stat_t fifo_stat;
    back_stat_t back_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_height_reg <= GRID_HEIGHT_RST;
            grid_width_reg  <= GRID_WIDTH_RST;
            blur_amount_reg <= BLUR_AMOUNT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_BLUR_AMOUNT: blur_amount_reg <= cfg_wdata[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tg3_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .grid_height (grid_height_reg),
        .grid_width  (grid_width_reg),
        .fifo_stat   (fifo_stat),
        .back_stat   (back_stat),
        .push        (push),
        .cmd         (push_cmd)
    );

    tg3_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (fifo_stat)
    );

    tg3_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .blur_amount (blur_amount_reg),
        .fifo_stat   (fifo_stat),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .stat        (back_stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // no request taken while the store is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.clearing |-> !s_ready)
        else $error("request accepted during clearing pass");

    // queue never pushed when full
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_stat.full)
        else $error("command queue overflow");

    // never popped when empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !fifo_stat.empty)
        else $error("command queue underflow");

    // out-of-grid reads report zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_of_range) |-> (m_data.blurred_value == '0))
        else $error("out-of-range result carries a value");

endmodule

// ----- sim/grid_blur_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_blur_checker
// Watches the request, result and config ports of the toroidal blur unit.
// Keeps its own copy of the cell grid and the size and blur registers, and
// works out the blurred value for every read request it sees accepted.
// Each result is checked field by field against the oldest outstanding read.
// ----------------------------------------------------------------------------
module grid_blur_checker
    import tg3_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_t                s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_t               m_data,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output int                 mismatches,
    output int                 reads_in_flight
);

    logic [VAL_W-1:0]  cells [0:(1 << ADDR_W) - 1];
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    logic [VAL_W-1:0]  spill_reg;
    out_t              outstanding_reads [$];

    // size register as the grid sees it: zero means one, clipped at the maximum
    function automatic int unsigned span(logic [SIZE_W-1:0] v, logic [SIZE_W-1:0] lim);
        if (v == '0) return 1;
        if (v > lim) return 32'(lim);
        return 32'(v);
    endfunction

    function automatic logic in_grid(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        return (r < span(rows_reg, MAX_ROWS)) && (c < span(cols_reg, MAX_COLS));
    endfunction

    function automatic out_t blur_cell(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        int unsigned      h;
        int unsigned      w;
        logic [ROW_W-1:0] up;
        logic [ROW_W-1:0] dn;
        logic [COL_W-1:0] lf;
        logic [COL_W-1:0] rt;
        logic [63:0]      centre;
        logic [63:0]      sides;
        logic [63:0]      diags;
        logic [63:0]      num;
        logic [63:0]      q;
        out_t             res;
        h = span(rows_reg, MAX_ROWS);
        w = span(cols_reg, MAX_COLS);
        res.out_row       = r;
        res.out_col       = c;
        res.blurred_value = '0;
        res.out_of_range  = 1'b1;
        if (!in_grid(r, c)) return res;
        // wrapped neighbours; tiny grids land on the same cell several times
        up = (r == 0) ? ROW_W'(h - 1) : r - 1'b1;
        dn = (int'(r) + 1 == h) ? '0 : r + 1'b1;
        lf = (c == 0) ? COL_W'(w - 1) : c - 1'b1;
        rt = (int'(c) + 1 == w) ? '0 : c + 1'b1;
        centre = 64'(cells[{r, c}]);
        sides  = 64'(cells[{up, c}]) + 64'(cells[{dn, c}])
               + 64'(cells[{r, lf}]) + 64'(cells[{r, rt}]);
        diags  = 64'(cells[{up, lf}]) + 64'(cells[{up, rt}])
               + 64'(cells[{dn, lf}]) + 64'(cells[{dn, rt}]);
        // weights over 12 * 2^16: centre 12(1-b), side 2b, corner b
        num = 64'd12 * (64'd65536 - 64'(spill_reg)) * centre
            + 64'd2 * 64'(spill_reg) * sides
            + 64'(spill_reg) * diags;
        q = (num + 64'd393216) / 64'd786432;
        if (q > 64'd65535) q = 64'd65535;
        res.blurred_value = q[VAL_W-1:0];
        res.out_of_range  = 1'b0;
        return res;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        int   bad;
        bad = 0;
        if (!aresetn) begin
            rows_reg  = GRID_HEIGHT_RST;
            cols_reg  = GRID_WIDTH_RST;
            spill_reg = BLUR_AMOUNT_RST;
            for (int i = 0; i < (1 << ADDR_W); i++) cells[i] = '0;
            outstanding_reads.delete();
            mismatches      <= 0;
            reads_in_flight <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_GRID_HEIGHT: rows_reg  = cfg_wdata[SIZE_W-1:0];
                    CFG_GRID_WIDTH:  cols_reg  = cfg_wdata[SIZE_W-1:0];
                    CFG_BLUR_AMOUNT: spill_reg = cfg_wdata[VAL_W-1:0];
                    default: ;
                endcase
            end
            // results first: a request taken at this edge cannot answer at it
            if (m_valid && m_ready) begin
                if (outstanding_reads.size() == 0) begin
                    $error("result for cell (%0d,%0d) with no read outstanding",
                           m_data.out_row, m_data.out_col);
                    bad++;
                end else begin
                    want = outstanding_reads.pop_front();
                    bad += field_diff("out_row", want.out_row, m_data.out_row);
                    bad += field_diff("out_col", want.out_col, m_data.out_col);
                    bad += field_diff("blurred_value", want.blurred_value,
                                      m_data.blurred_value);
                    bad += field_diff("out_of_range", want.out_of_range,
                                      m_data.out_of_range);
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.op == OP_READ) begin
                    outstanding_reads = {outstanding_reads,
                                         blur_cell(s_data.row, s_data.col)};
                end else if (in_grid(s_data.row, s_data.col)) begin
                    cells[{s_data.row, s_data.col}] = s_data.cell_value;
                end
            end
            mismatches      <= mismatches + bad;
            reads_in_flight <= outstanding_reads.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the toroidal 3x3 grid blur unit.
// A directed set of writes and reads around the wrapped corners and a tiny
// grid is followed by random phases over several grid sizes and blur
// amounts, with random idle bursts on both channels. The checker beside
// the unit predicts every read and reports mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import tg3_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_t                s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               cfg_we;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;

    int mismatches;
    int reads_in_flight;
    int gap_pct;
    int stall_pct;
    int stall_left;
    int cycles = 0;

    toroidal_grid_blur_3x3_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    grid_blur_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .reads_in_flight (reads_in_flight)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left = 0;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_req(logic op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                            logic [VAL_W-1:0] v);
        in_t req;
        req = '{op, r, c, v};
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // no request left to send: wait out outstanding reads and trailing writes
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reads_in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w,
                                logic [CFG_W-1:0] b);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_addr  <= CFG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_addr  <= CFG_BLUR_AMOUNT;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int grid_span(logic [CFG_W-1:0] v);
        if (v[SIZE_W-1:0] == '0) return 1;
        if (v[SIZE_W-1:0] > MAX_ROWS) return MAX_ROWS;
        return v[SIZE_W-1:0];
    endfunction

    // lean on the wrap edges, now and then step outside the grid
    function automatic logic [ROW_W-1:0] pick_coord(int n);
        int k;
        int band;
        k    = $urandom_range(0, 9);
        band = (n < 3) ? n : 3;
        if (k < 3) return ROW_W'($urandom_range(0, band - 1));
        if (k < 6) return ROW_W'(n - 1 - $urandom_range(0, band - 1));
        if (k < 9) return ROW_W'($urandom_range(0, n - 1));
        return ROW_W'($urandom_range(0, 63));
    endfunction

    task automatic run_phase(logic [CFG_W-1:0] h, logic [CFG_W-1:0] w,
                             logic [CFG_W-1:0] b, int count, int gap, int stall);
        int               rows;
        int               cols;
        logic [VAL_W-1:0] v;
        apply_config(h, w, b);
        rows      = grid_span(h);
        cols      = grid_span(w);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) begin
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = '1;
                default: v = VAL_W'($urandom);
            endcase
            send_req(($urandom_range(0, 1) == 1) ? OP_READ : OP_WRITE,
                     pick_coord(rows), pick_coord(cols), v);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_GRID_HEIGHT;
        cfg_wdata = '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: corners of the full grid see each other through the wrap
        gap_pct   = 25;
        stall_pct = 25;
        send_req(OP_READ,  6'd0,  6'd0,  16'hFFFF);
        send_req(OP_WRITE, 6'd0,  6'd0,  16'hFFFF);
        send_req(OP_WRITE, 6'd63, 6'd63, 16'hFFFF);
        send_req(OP_WRITE, 6'd0,  6'd63, 16'h8000);
        send_req(OP_WRITE, 6'd63, 6'd0,  16'h0001);
        send_req(OP_WRITE, 6'd1,  6'd0,  16'hAAAA);
        send_req(OP_WRITE, 6'd0,  6'd1,  16'h5555);
        send_req(OP_READ,  6'd0,  6'd0,  16'h0000);
        send_req(OP_READ,  6'd63, 6'd63, 16'h0000);
        send_req(OP_READ,  6'd0,  6'd63, 16'h0000);
        send_req(OP_READ,  6'd63, 6'd0,  16'h0000);
        send_req(OP_READ,  6'd1,  6'd1,  16'h0000);
        send_req(OP_READ,  6'd62, 6'd62, 16'h0000);

        // two rows by one column, full blur; upper bits of the size write are dropped
        apply_config(16'hFF82, 16'h0001, 16'hFFFF);
        send_req(OP_WRITE, 6'd1,  6'd0,  16'hFFFF);
        send_req(OP_WRITE, 6'd2,  6'd0,  16'h1234);
        send_req(OP_WRITE, 6'd0,  6'd1,  16'h4321);
        send_req(OP_READ,  6'd2,  6'd0,  16'h0000);
        send_req(OP_READ,  6'd0,  6'd1,  16'h0000);
        send_req(OP_READ,  6'd63, 6'd63, 16'h0000);
        send_req(OP_READ,  6'd0,  6'd0,  16'h0000);
        send_req(OP_READ,  6'd1,  6'd0,  16'h0000);

        run_phase(16'd64,   16'd64,  16'd0,           150, 30, 30);
        run_phase(16'hFF80, 16'd0,   16'hFFFF,        120, 20, 20);
        run_phase(16'd1,    16'd64,  16'd32768,       150, 0,  0);
        run_phase(16'd64,   16'd2,   16'd7864,        150, 40, 40);
        run_phase(16'd127,  16'd127, 16'hFFFF,        170, 25, 25);
        run_phase(16'd3,    16'd5,   16'd1,           150, 30, 30);
        run_phase(16'd37,   16'd17,  CFG_W'($urandom), 170, 20, 20);
        run_phase(16'd65,   16'd100, 16'd12345,       170, 30, 30);
        // back to reset values, no idling to the end
        run_phase(16'd64,   16'd64,  16'd7864,        150, 0,  0);

        drain();
        if (mismatches == 0 && reads_in_flight == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
